// ===== hdl/tsa_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Truss stiffness assembler package
// Shared types and fixed constants of the truss stiffness assembler.
// ---------------------------------------------------------------------------
package tsa_pkg;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_IDX = 2'd1;
  localparam logic [1:0] ST_ZERO_L  = 2'd2;

  localparam int DIV_W = 64;
  localparam int ACC_W = 40;

  localparam logic [30:0]      COS_MAX = 31'h7FFF_FFFF;
  localparam logic [ACC_W-1:0] ACC_HI  = 40'h7F_FFFF_FFFF;
  localparam logic [ACC_W-1:0] ACC_LO  = 40'h80_0000_0000;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== hdl/tsa_div.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Shared divider
// Restoring unsigned divider that retires one quotient bit per cycle.
// ---------------------------------------------------------------------------
module tsa_div (
  input  logic              clk,
  input  logic              rst,
  input  tsa_pkg::div_req_t req,
  output tsa_pkg::div_rsp_t rsp
);

  logic [tsa_pkg::DIV_W-1:0] rem;
  logic [tsa_pkg::DIV_W-1:0] quo;
  logic [tsa_pkg::DIV_W-1:0] den;
  logic [5:0]                cnt;
  logic                      busy;
  logic                      done;
  logic [tsa_pkg::DIV_W:0]   shifted;
  logic [tsa_pkg::DIV_W:0]   diff;
  logic [tsa_pkg::DIV_W-1:0] rem_next;
  logic [tsa_pkg::DIV_W-1:0] quo_next;

  always_comb begin
    shifted  = {rem, quo[tsa_pkg::DIV_W-1]};
    diff     = shifted - {1'b0, den};
    rem_next = diff[tsa_pkg::DIV_W] ? shifted[tsa_pkg::DIV_W-1:0]
                                    : diff[tsa_pkg::DIV_W-1:0];
    quo_next = {quo[tsa_pkg::DIV_W-2:0], ~diff[tsa_pkg::DIV_W]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.num;
      den <= req.den;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule
`default_nettype wire

// ===== hdl/tsa_store.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Stiffness store
// Single write, single read matrix memory with a registered read port.
// ---------------------------------------------------------------------------
module tsa_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [tsa_pkg::ACC_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [tsa_pkg::ACC_W-1:0] rdata
);

  logic [tsa_pkg::ACC_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/truss_stiffness_assembler_top.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Truss stiffness assembler
// Direct stiffness assembly of a plane truss into a stored global matrix.
// ---------------------------------------------------------------------------
// The block takes one request at a time. After reset, and for every clear
// request, a sweep zeroes all MAX_DOF*MAX_DOF entries of the matrix store one
// entry per cycle, during which no request is taken. An add-member request
// makes five divisions on the shared 64-step divider, three magnitude
// products, and sixteen read-modify-write updates, each a read state and a
// write state on the single store port. Requests with a bad index or a zero
// length skip the computation and go straight to the response.
module truss_stiffness_assembler_top #(
  parameter int MAX_DOF = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [5:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic signed [31:0] x_start,
  input  logic signed [31:0] y_start,
  input  logic signed [31:0] x_end,
  input  logic signed [31:0] y_end,
  input  logic [31:0]        member_length,
  input  logic [5:0]         dof_x_start,
  input  logic [5:0]         dof_y_start,
  input  logic [5:0]         dof_x_end,
  input  logic [5:0]         dof_y_end,
  input  logic [5:0]         read_row,
  input  logic [5:0]         read_col,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic signed [39:0] value
);

  localparam int DEPTH = MAX_DOF * MAX_DOF;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DIVGO = 4'd2;
  localparam logic [3:0] S_DIVW  = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_ACCR  = 4'd5;
  localparam logic [3:0] S_ACCW  = 4'd6;
  localparam logic [3:0] S_RD    = 4'd7;
  localparam logic [3:0] S_RDW   = 4'd8;
  localparam logic [3:0] S_PUSH  = 4'd9;

  logic [3:0]  state;
  logic [5:0]  dof_count;
  logic [AW-1:0] clr_addr;
  logic [31:0] len;
  logic [32:0] dmag [2];
  logic        dneg [2];
  logic [5:0]  idx [4];
  logic [5:0]  rrow;
  logic [5:0]  rcol;
  logic [30:0] cmag [2];
  logic        cneg [2];
  logic [61:0] prod;
  logic        prod_neg;
  logic signed [39:0] blk [3];
  logic [2:0]  dsel;
  logic [3:0]  k;
  logic [1:0]  res_status;
  logic signed [39:0] res_value;
  logic        op_clear_pending;

  tsa_pkg::div_req_t div_req;
  tsa_pkg::div_rsp_t div_rsp;

  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [tsa_pkg::ACC_W-1:0] mem_wdata;
  logic [AW-1:0]             mem_raddr;
  logic [tsa_pkg::ACC_W-1:0] mem_rdata;

  logic [8:0]  bound;
  logic        add_idx_ok;
  logic        rd_idx_ok;
  logic [AW-1:0] acc_addr;
  logic [AW-1:0] rd_addr;
  logic signed [39:0] elem;
  logic signed [40:0] sum;
  logic [39:0] sat_sum;
  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic [39:0] term_mag;
  logic [30:0] u_mag;
  logic [30:0] v_mag;

  function automatic logic idx_ok(input logic [5:0] kk, input logic [8:0] bnd);
    idx_ok = (kk != 6'd0) && ({3'b000, kk} <= bnd);
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [5:0] r, input logic [5:0] c);
    logic [5:0] rm;
    logic [5:0] cm;
    rm = r - 6'd1;
    cm = c - 6'd1;
    addr_of = AW'(AW'(rm) * AW'(MAX_DOF) + AW'(cm));
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    bound = ({3'b000, dof_count} < 9'(MAX_DOF)) ? {3'b000, dof_count} : 9'(MAX_DOF);
    add_idx_ok = idx_ok(dof_x_start, bound) && idx_ok(dof_y_start, bound) &&
                 idx_ok(dof_x_end, bound) && idx_ok(dof_y_end, bound);
    rd_idx_ok  = idx_ok(read_row, bound) && idx_ok(read_col, bound);
    dx = 33'(x_end) - 33'(x_start);
    dy = 33'(y_end) - 33'(y_start);
    acc_addr = addr_of(idx[k[3:2]], idx[k[1:0]]);
    rd_addr  = addr_of(rrow, rcol);
    elem = blk[2'(k[2]) + 2'(k[0])];
    if (k[3] ^ k[1]) begin
      elem = -elem;
    end
    sum = {mem_rdata[39], mem_rdata} + {elem[39], elem};
    if (sum[40] != sum[39]) begin
      sat_sum = sum[40] ? tsa_pkg::ACC_LO : tsa_pkg::ACC_HI;
    end else begin
      sat_sum = sum[39:0];
    end
    term_mag = div_rsp.quo[39:0];
    u_mag = (dsel == 3'd4) ? cmag[1] : cmag[0];
    v_mag = (dsel == 3'd2) ? cmag[0] : cmag[1];
  end

  always_comb begin
    div_req.start = (state == S_DIVGO);
    if (dsel < 3'd2) begin
      div_req.num = 64'({dmag[dsel[0]], 30'b0}) + 64'(len >> 1);
      div_req.den = 64'(len);
    end else begin
      div_req.num = 64'(prod) + 64'({len, 27'b0});
      div_req.den = 64'({len, 28'b0});
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = acc_addr;
    mem_wdata = sat_sum;
    mem_raddr = (state == S_RD) ? rd_addr : acc_addr;
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (state == S_ACCW) begin
      mem_we = 1'b1;
    end
  end

  tsa_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  tsa_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      dof_count <= 6'd32;
      out_valid <= 1'b0;
      dsel      <= '0;
      k         <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        dof_count <= cfg_data;
      end
      if (state == S_PUSH && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            clr_addr <= '0;
            state    <= (res_status == tsa_pkg::ST_OK && op_clear_pending) ? S_PUSH : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            dsel <= '0;
            k    <= '0;
            if (op == tsa_pkg::OP_CLEAR) begin
              state <= S_CLEAR;
            end else if (op == tsa_pkg::OP_ADD) begin
              if (!add_idx_ok || member_length == 32'd0) begin
                state <= S_PUSH;
              end else begin
                state <= S_DIVGO;
              end
            end else if (op == tsa_pkg::OP_READ) begin
              state <= rd_idx_ok ? S_RD : S_PUSH;
            end else begin
              state <= S_PUSH;
            end
          end
        end
        S_DIVGO: begin
          state <= S_DIVW;
        end
        S_DIVW: begin
          if (div_rsp.done) begin
            dsel <= dsel + 3'd1;
            if (dsel == 3'd0) begin
              state <= S_DIVGO;
            end else if (dsel == 3'd4) begin
              state <= S_ACCR;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          state <= S_DIVGO;
        end
        S_ACCR: begin
          state <= S_ACCW;
        end
        S_ACCW: begin
          k <= k + 4'd1;
          state <= (k == 4'd15) ? S_PUSH : S_ACCR;
        end
        S_RD: begin
          state <= S_RDW;
        end
        S_RDW: begin
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_clear_pending <= 1'b0;
      res_status       <= tsa_pkg::ST_OK;
    end else if (state == S_IDLE && in_valid) begin
      op_clear_pending <= (op == tsa_pkg::OP_CLEAR);
      if (op == tsa_pkg::OP_ADD) begin
        if (!add_idx_ok) begin
          res_status <= tsa_pkg::ST_BAD_IDX;
        end else if (member_length == 32'd0) begin
          res_status <= tsa_pkg::ST_ZERO_L;
        end else begin
          res_status <= tsa_pkg::ST_OK;
        end
      end else if (op == tsa_pkg::OP_READ) begin
        res_status <= rd_idx_ok ? tsa_pkg::ST_OK : tsa_pkg::ST_BAD_IDX;
      end else begin
        res_status <= tsa_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      len       <= member_length;
      dneg[0]   <= dx[32];
      dneg[1]   <= dy[32];
      dmag[0]   <= dx[32] ? -dx : dx;
      dmag[1]   <= dy[32] ? -dy : dy;
      idx[0]    <= dof_x_start;
      idx[1]    <= dof_y_start;
      idx[2]    <= dof_x_end;
      idx[3]    <= dof_y_end;
      rrow      <= read_row;
      rcol      <= read_col;
      res_value <= '0;
    end
    if (state == S_DIVW && div_rsp.done) begin
      if (dsel < 3'd2) begin
        cneg[dsel[0]] <= dneg[dsel[0]];
        cmag[dsel[0]] <= (div_rsp.quo > 64'(tsa_pkg::COS_MAX)) ? tsa_pkg::COS_MAX
                                                              : div_rsp.quo[30:0];
      end else begin
        blk[2'(dsel - 3'd2)] <= prod_neg ? -signed'(term_mag) : signed'(term_mag);
      end
    end
    if (state == S_MUL) begin
      prod     <= u_mag * v_mag;
      prod_neg <= (dsel == 3'd3) ? (cneg[0] ^ cneg[1]) : 1'b0;
    end
    if (state == S_RDW) begin
      res_value <= signed'(mem_rdata);
    end
    if (state == S_PUSH && (!out_valid || out_ready)) begin
      status <= res_status;
      value  <= res_value;
    end
  end

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIVW)
    else $error("divider finished outside its wait state");

  a_write_only_clear_or_acc: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_CLEAR || state == S_ACCW))
    else $error("store written outside clear or accumulate");

  a_sixteen_updates: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACCW && k == 4'd15) |=> state == S_PUSH)
    else $error("accumulate did not finish after sixteen updates");

endmodule
`default_nettype wire
